@@ hw/rtl/bdeque_pkg.sv @@
package bdeque_pkg;

	// command codes carried on the kind field
	typedef enum logic [3:0] {
		KIND_PUSH_FRONT = 4'd0,
		KIND_PUSH_BACK  = 4'd1,
		KIND_POP_FRONT  = 4'd2,
		KIND_POP_BACK   = 4'd3,
		KIND_CLEAR      = 4'd4,
		KIND_REMOVE     = 4'd5,
		KIND_DUMP_ALL   = 4'd6,
		KIND_DUMP_FIRST = 4'd7,
		KIND_DUMP_LAST  = 4'd8
	} kind_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SRCH,
		ST_SHIFT,
		ST_EMIT,
		ST_MARK
	} state_t;

	// read address select: start position, next position, position after next
	typedef enum logic [1:0] {
		RD_START,
		RD_NEXT,
		RD_NEXT2
	} rd_sel_t;

	// controller to datapath
	typedef struct packed {
		logic    cap;
		logic    push_front;
		logic    push_back;
		logic    pop_front;
		logic    pop_back;
		logic    clear;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    pos_inc;
		logic    shift_wr;
		logic    dec_occ;
		logic    out_load_data;
		logic    out_load_mark;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [3:0] kind;
		logic       full;
		logic       empty;
		logic       match;
		logic       more;
		logic       more2;
		logic       is_last;
		logic       n_zero;
		logic       out_free;
	} status_t;

endpackage

@@ hw/rtl/bdeque_ctrl.sv @@
module bdeque_ctrl
	import bdeque_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t stat,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// input word taken only between commands
	assign in_stall = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				case (stat.kind)
					KIND_PUSH_FRONT: cmd.push_front = !stat.full;
					KIND_PUSH_BACK:  cmd.push_back  = !stat.full;
					KIND_POP_FRONT:  cmd.pop_front  = !stat.empty;
					KIND_POP_BACK:   cmd.pop_back   = !stat.empty;
					KIND_CLEAR:      cmd.clear      = 1'b1;
					KIND_REMOVE: begin
						if (!stat.empty) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_START;
							state_d    = ST_SRCH;
						end
					end
					KIND_DUMP_ALL, KIND_DUMP_FIRST, KIND_DUMP_LAST: begin
						if (stat.n_zero) begin
							state_d = ST_MARK;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_START;
							state_d    = ST_EMIT;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			// compare one entry a cycle, next read already issued
			ST_SRCH: begin
				if (stat.match) begin
					if (stat.more) begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_NEXT;
					end
					state_d = ST_SHIFT;
				end else if (stat.more) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RD_NEXT;
					cmd.pos_inc = 1'b1;
				end else begin
					state_d = ST_IDLE;
				end
			end
			// move later entries one place toward the front
			ST_SHIFT: begin
				if (stat.more) begin
					cmd.shift_wr = 1'b1;
					cmd.pos_inc  = 1'b1;
					if (stat.more2) begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_NEXT2;
					end
				end else begin
					cmd.dec_occ = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.out_load_data = 1'b1;
					if (stat.is_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.rd_en   = 1'b1;
						cmd.rd_sel  = RD_NEXT;
						cmd.pos_inc = 1'b1;
					end
				end
			end
			ST_MARK: begin
				if (stat.out_free) begin
					cmd.out_load_mark = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ hw/rtl/bdeque_dpath.sv @@
module bdeque_dpath
	import bdeque_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [3:0]         kind,
	input  logic signed [31:0] operand,
	input  logic               out_stall,
	output logic               out_valid,
	output logic signed [31:0] element,
	output logic               no_data,
	output logic               last_of_dump,
	input  cmd_t               cmd,
	output status_t            stat
);

	localparam int AW = $clog2(CAPACITY);
	localparam int OW = $clog2(CAPACITY + 1);
	localparam int PW = $clog2(CAPACITY + 2);
	localparam logic [OW-1:0] CAP_O = OW'(CAPACITY);
	localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

	// circular storage
	logic [31:0] mem [CAPACITY];

	logic [3:0]         kind_q;
	logic signed [31:0] operand_q;
	logic [AW-1:0]      front_q;
	logic [OW-1:0]      occ_q;
	logic [PW-1:0]      pos_q;
	logic [PW-1:0]      end_q;
	logic [31:0]        rdata_q;
	logic               out_valid_q;
	logic signed [31:0] element_q;
	logic               no_data_q;
	logic               last_q;

	logic [30:0]   cnt;
	logic [30:0]   cnt_l;
	logic [OW-1:0] n;
	logic [OW-1:0] start;
	logic [PW-1:0] occ_p;
	logic [AW-1:0] front_dec;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic          out_free;

	// physical slot of a logical position
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] f, input logic [PW-1:0] p);
		logic [PW:0] s;
		s = (PW + 1)'(f) + (PW + 1)'(p);
		if (s >= (PW + 1)'(CAPACITY)) begin
			s = s - (PW + 1)'(CAPACITY);
		end
		return s[AW-1:0];
	endfunction

	// command word capture
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			kind_q    <= kind;
			operand_q <= operand;
		end
	end

	// dump range: count, start position
	always_comb begin
		cnt   = operand_q[31] ? 31'd0 : operand_q[30:0];
		cnt_l = (kind_q == KIND_DUMP_LAST && cnt == 31'd0) ? 31'd1 : cnt;
		if (kind_q == KIND_DUMP_ALL || cnt_l >= 31'(occ_q)) begin
			n = occ_q;
		end else begin
			n = cnt_l[OW-1:0];
		end
		start = (kind_q == KIND_DUMP_LAST) ? occ_q - n : '0;
	end

	assign occ_p     = PW'(occ_q);
	assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - AW'(1);

	// read address
	always_comb begin
		case (cmd.rd_sel)
			RD_START: rd_addr = slot(front_q, PW'(start));
			RD_NEXT:  rd_addr = slot(front_q, pos_q + PW'(1));
			RD_NEXT2: rd_addr = slot(front_q, pos_q + PW'(2));
			default:  rd_addr = slot(front_q, pos_q);
		endcase
	end

	// write port
	always_comb begin
		wr_en   = cmd.push_front | cmd.push_back | cmd.shift_wr;
		wr_addr = slot(front_q, pos_q);
		wr_data = rdata_q;
		if (cmd.push_front) begin
			wr_addr = front_dec;
			wr_data = operand_q;
		end else if (cmd.push_back) begin
			wr_addr = slot(front_q, occ_p);
			wr_data = operand_q;
		end
	end

	// memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// front and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			occ_q   <= '0;
		end else if (cmd.clear) begin
			front_q <= '0;
			occ_q   <= '0;
		end else if (cmd.push_front) begin
			front_q <= front_dec;
			occ_q   <= occ_q + OW'(1);
		end else if (cmd.push_back) begin
			occ_q <= occ_q + OW'(1);
		end else if (cmd.pop_front) begin
			front_q <= slot(front_q, PW'(1));
			occ_q   <= occ_q - OW'(1);
		end else if (cmd.pop_back || cmd.dec_occ) begin
			occ_q <= occ_q - OW'(1);
		end
	end

	// walk position and end of dump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			end_q <= '0;
		end else if (cmd.rd_en && cmd.rd_sel == RD_START) begin
			pos_q <= PW'(start);
			end_q <= PW'(start) + PW'(n) - PW'(1);
		end else if (cmd.pos_inc) begin
			pos_q <= pos_q + PW'(1);
		end
	end

	// output register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load_data || cmd.out_load_mark) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load_data) begin
			element_q <= rdata_q;
			no_data_q <= 1'b0;
			last_q    <= (pos_q == end_q);
		end else if (cmd.out_load_mark) begin
			element_q <= '0;
			no_data_q <= 1'b1;
			last_q    <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign element      = element_q;
	assign no_data      = no_data_q;
	assign last_of_dump = last_q;

	// status back to the controller
	always_comb begin
		stat.kind     = kind_q;
		stat.full     = (occ_q == CAP_O);
		stat.empty    = (occ_q == '0);
		stat.match    = (rdata_q == operand_q);
		stat.more     = ((pos_q + PW'(1)) < occ_p);
		stat.more2    = ((pos_q + PW'(2)) < occ_p);
		stat.is_last  = (pos_q == end_q);
		stat.n_zero   = (n == '0);
		stat.out_free = out_free;
	end

endmodule

@@ hw/rtl/bounded_deque_with_delete_by_value.sv @@
// channel | valid     | stall     | words
// --------+-----------+-----------+-------------------------------------
// in      | in_valid  | in_stall  | kind, operand
// out     | out_valid | out_stall | element, no_data, last_of_dump
//
// A command is captured in the idle state and decoded in the execute state, where
// push, pop and clear finish. Remove compares entries from the front, one read a
// cycle, then on a hit moves later entries forward, one read and one write a cycle.
// A dump walks its entries one word a cycle from the single read port while the
// output is not stalled; a dump of no entries gives a marker word. Reset clears
// front, occupancy and output valid, not entries. Output stall holds dumps and input.
module bounded_deque_with_delete_by_value
	import bdeque_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         kind,
	input  logic signed [31:0] operand,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] element,
	output logic               no_data,
	output logic               last_of_dump
);

	cmd_t    cmd;
	status_t stat;

	// sequencer
	bdeque_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// storage, pointers and output register
	bdeque_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.kind         (kind),
		.operand      (operand),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.element      (element),
		.no_data      (no_data),
		.last_of_dump (last_of_dump),
		.cmd          (cmd),
		.stat         (stat)
	);

	// one command in flight at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("command taken while previous one busy");

	// a marker word is always the final, empty word of its dump
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && no_data) |-> (last_of_dump && element == 32'sd0))
		else $error("bad marker word");

	// output register is loaded only when free
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load_data || cmd.out_load_mark) |-> stat.out_free)
		else $error("output word overwritten");

	// full and empty are exclusive
	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.full && stat.empty))
		else $error("store both full and empty");

endmodule

@@ dv/bdeque_checker.sv @@
module bdeque_checker
	import bdeque_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [3:0]         kind,
	input  logic signed [31:0] operand,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] element,
	input  logic               no_data,
	input  logic               last_of_dump,
	output int                 err_count,
	output int                 pending,
	output int                 words_checked
);

	// one dump word as it should appear on the output channel
	typedef struct packed {
		logic signed [31:0] element;
		logic               no_data;
		logic               is_last;
	} dump_word_t;

	dump_word_t expected_words[$];
	dump_word_t want;

	// shadow of the deque contents
	logic [31:0] shadow_store [CAPACITY];
	int          shadow_front;
	int          shadow_fill;
	int          errs;
	int          checked;

	function automatic int slot_of(input int pos);
		return (shadow_front + pos) % CAPACITY;
	endfunction

	// queue the words a dump of count entries starting at first produces
	task automatic emit_span(input int first, input int count);
		int k;
		if (count == 0) begin
			expected_words.push_back('{element: '0, no_data: 1'b1, is_last: 1'b1});
		end else begin
			for (k = 0; k < count; k++)
				expected_words.push_back('{element: shadow_store[slot_of(first + k)],
					no_data: 1'b0, is_last: (k == count - 1)});
		end
	endtask

	// advance the shadow deque by one command
	task automatic apply_command(input logic [3:0] k, input logic signed [31:0] v);
		int  cnt;
		int  n;
		int  i;
		int  j;
		bit  found;
		cnt = v[31] ? 0 : int'(v);
		case (k)
			KIND_PUSH_FRONT: begin
				if (shadow_fill < CAPACITY) begin
					shadow_front = (shadow_front + CAPACITY - 1) % CAPACITY;
					shadow_store[shadow_front] = v;
					shadow_fill++;
				end
			end
			KIND_PUSH_BACK: begin
				if (shadow_fill < CAPACITY) begin
					shadow_store[slot_of(shadow_fill)] = v;
					shadow_fill++;
				end
			end
			KIND_POP_FRONT: begin
				if (shadow_fill > 0) begin
					shadow_front = (shadow_front + 1) % CAPACITY;
					shadow_fill--;
				end
			end
			KIND_POP_BACK: begin
				if (shadow_fill > 0)
					shadow_fill--;
			end
			KIND_CLEAR: begin
				shadow_fill = 0;
				shadow_front = 0;
			end
			KIND_REMOVE: begin
				// first match from the front, later entries close the hole
				found = 1'b0;
				for (i = 0; i < shadow_fill && !found; i++) begin
					if (shadow_store[slot_of(i)] == v) begin
						for (j = i; j + 1 < shadow_fill; j++)
							shadow_store[slot_of(j)] = shadow_store[slot_of(j + 1)];
						shadow_fill--;
						found = 1'b1;
					end
				end
			end
			KIND_DUMP_ALL: emit_span(0, shadow_fill);
			KIND_DUMP_FIRST: begin
				n = (cnt < shadow_fill) ? cnt : shadow_fill;
				emit_span(0, n);
			end
			KIND_DUMP_LAST: begin
				// zero or negative count acts as one
				if (cnt < 1)
					cnt = 1;
				n = (cnt < shadow_fill) ? cnt : shadow_fill;
				emit_span(shadow_fill - n, n);
			end
			default: ;
		endcase
	endtask

	// compare output words, then feed accepted commands to the shadow
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			shadow_front = 0;
			shadow_fill = 0;
			errs = 0;
			checked = 0;
			err_count <= 0;
			pending <= 0;
			words_checked <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				checked++;
				if (expected_words.size() == 0) begin
					$display("%0t: extra word, expected none, actual %0d/%0b/%0b",
						$time, element, no_data, last_of_dump);
					errs++;
				end else begin
					want = expected_words.pop_front();
					if (element !== want.element) begin
						$display("%0t: element mismatch, expected %0d actual %0d",
							$time, want.element, element);
						errs++;
					end
					if (no_data !== want.no_data) begin
						$display("%0t: no_data mismatch, expected %0b actual %0b",
							$time, want.no_data, no_data);
						errs++;
					end
					if (last_of_dump !== want.is_last) begin
						$display("%0t: last_of_dump mismatch, expected %0b actual %0b",
							$time, want.is_last, last_of_dump);
						errs++;
					end
				end
			end
			if (in_valid && !in_stall)
				apply_command(kind, operand);
			err_count <= errs;
			pending <= expected_words.size();
			words_checked <= checked;
		end
	end

endmodule

@@ dv/tb_bounded_deque_with_delete_by_value.sv @@
module tb_bounded_deque_with_delete_by_value
	import bdeque_pkg::*;
();

	localparam int CAPACITY      = 64;
	localparam int RANDOM_ITEMS  = 300;
	localparam int IDLE_LIMIT    = 4000;
	localparam int DRAIN_CYCLES  = 200;
	localparam int SEG_FILL      = 0;
	localparam int SEG_DRAIN     = 1;
	localparam int SEG_MIXED     = 2;
	localparam int SEG_REMOVE    = 3;
	localparam int SEG_OVERFLOW  = 4;
	localparam int FIRST_UNUSED_KIND = 9;
	localparam int LAST_KIND_CODE    = 15;
	localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
	localparam logic signed [31:0] MOST_POSITIVE = 32'sh7fff_ffff;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [3:0]         kind = '0;
	logic signed [31:0] operand = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] element;
	logic               no_data;
	logic               last_of_dump;

	int errors;
	int pending;
	int words_checked;

	int commands_sent = 0;
	int directed_cmds = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit stall_now = 1'b0;
	bit calm = 1'b0;
	logic signed [31:0] value_pool[$];

	always #10 clk = ~clk;

	bounded_deque_with_delete_by_value #(.CAPACITY(CAPACITY)) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.operand     (operand),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.element     (element),
		.no_data     (no_data),
		.last_of_dump(last_of_dump)
	);

	bdeque_checker #(.CAPACITY(CAPACITY)) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.operand      (operand),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.element      (element),
		.no_data      (no_data),
		.last_of_dump (last_of_dump),
		.err_count    (errors),
		.pending      (pending),
		.words_checked(words_checked)
	);

	// output back-pressure: mostly short runs, now and then a long stall
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else if ($urandom_range(0, 99) < 60) begin
			stall_now = 1'b0;
			stall_left = $urandom_range(0, 6);
		end else begin
			stall_now = 1'b1;
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 3);
		end
		out_stall <= stall_now && !calm;
	end

	// watchdog on cycles where neither channel moves a word
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// small values give duplicates for remove, the rest spans all bits
	function automatic logic signed [31:0] push_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $urandom_range(0, 8) - 4;
		if (r < 45)
			return MOST_NEGATIVE;
		if (r < 50)
			return MOST_POSITIVE;
		return $urandom;
	endfunction

	function automatic logic signed [31:0] remove_value();
		if (value_pool.size() > 0 && $urandom_range(0, 99) < 70)
			return value_pool[$urandom_range(0, value_pool.size() - 1)];
		return push_value();
	endfunction

	// dump counts: mostly small, some past capacity, negative and huge
	function automatic logic signed [31:0] dump_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return $urandom_range(0, 8);
		if (r < 75)
			return $urandom_range(9, CAPACITY + 6);
		if (r < 88)
			return $urandom | 32'h8000_0000;
		return $urandom & 32'h7fff_ffff;
	endfunction

	function automatic logic signed [31:0] operand_for(input logic [3:0] k);
		case (k)
			KIND_PUSH_FRONT, KIND_PUSH_BACK: return push_value();
			KIND_REMOVE:                     return remove_value();
			KIND_DUMP_FIRST, KIND_DUMP_LAST: return dump_count();
			default:                         return $urandom;
		endcase
	endfunction

	function automatic logic [3:0] choose_kind(input int seg);
		int r;
		int w_push;
		int w_pop;
		int w_rem;
		int w_dump;
		int w_clr;
		case (seg)
			SEG_FILL: begin
				w_push = 65; w_pop = 5; w_rem = 10; w_dump = 18; w_clr = 0;
			end
			SEG_DRAIN: begin
				w_push = 15; w_pop = 45; w_rem = 15; w_dump = 18; w_clr = 5;
			end
			SEG_REMOVE: begin
				w_push = 35; w_pop = 5; w_rem = 38; w_dump = 20; w_clr = 0;
			end
			SEG_MIXED: begin
				w_push = 35; w_pop = 20; w_rem = 15; w_dump = 25; w_clr = 2;
			end
			default: begin
				w_push = 35; w_pop = 20; w_rem = 15; w_dump = 25; w_clr = 2;
			end
		endcase
		r = $urandom_range(0, 99);
		if (r < w_push)
			return $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
		r -= w_push;
		if (r < w_pop)
			return $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
		r -= w_pop;
		if (r < w_rem)
			return KIND_REMOVE;
		r -= w_rem;
		if (r < w_dump) begin
			r = $urandom_range(0, 2);
			return (r == 0) ? KIND_DUMP_ALL : (r == 1) ? KIND_DUMP_FIRST : KIND_DUMP_LAST;
		end
		r -= w_dump;
		if (r < w_clr)
			return KIND_CLEAR;
		return 4'($urandom_range(FIRST_UNUSED_KIND, LAST_KIND_CODE));
	endfunction

	// drive one command word and hold it until the block takes it
	task automatic send_command(input logic [3:0] k, input logic signed [31:0] v);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= k;
		operand <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// recent push values, reused as remove targets
		if (k == KIND_PUSH_FRONT || k == KIND_PUSH_BACK) begin
			value_pool.push_back(v);
			if (value_pool.size() > 48)
				void'(value_pool.pop_front());
		end
		if (k <= KIND_DUMP_LAST)
			commands_sent++;
	endtask

	initial begin
		int seg;
		logic [3:0] k;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty store, extremes, count corner cases
		send_command(KIND_DUMP_ALL, 0);
		send_command(KIND_DUMP_LAST, 0);
		send_command(KIND_POP_FRONT, 0);
		send_command(KIND_POP_BACK, 0);
		send_command(KIND_PUSH_BACK, MOST_POSITIVE);
		send_command(KIND_PUSH_FRONT, MOST_NEGATIVE);
		send_command(KIND_PUSH_BACK, 0);
		send_command(KIND_PUSH_FRONT, -1);
		send_command(KIND_PUSH_BACK, 5);
		send_command(KIND_PUSH_BACK, 0);
		send_command(KIND_DUMP_ALL, 0);
		send_command(KIND_DUMP_FIRST, 0);
		send_command(KIND_DUMP_FIRST, MOST_NEGATIVE);
		send_command(KIND_DUMP_FIRST, 2);
		send_command(KIND_DUMP_FIRST, MOST_POSITIVE);
		send_command(KIND_DUMP_LAST, -1);
		send_command(KIND_DUMP_LAST, 100);
		send_command(KIND_REMOVE, 12345);
		send_command(KIND_REMOVE, 0);
		send_command(KIND_REMOVE, -1);
		send_command(KIND_POP_FRONT, 0);
		send_command(KIND_POP_BACK, 0);
		send_command(KIND_DUMP_ALL, 0);
		// popping the only entry
		send_command(KIND_CLEAR, 0);
		send_command(KIND_PUSH_FRONT, 7);
		send_command(KIND_POP_BACK, 0);
		send_command(KIND_DUMP_FIRST, 3);
		send_command(4'(LAST_KIND_CODE), 42);
		send_command(4'(FIRST_UNUSED_KIND), -42);
		directed_cmds = commands_sent;

		// random: segments biased toward filling, draining or removing, plus mixed and overflow segments
		while (commands_sent < directed_cmds + RANDOM_ITEMS) begin
			seg = $urandom_range(SEG_FILL, SEG_OVERFLOW);
			calm = ($urandom_range(0, 5) == 0);
			if (seg == SEG_OVERFLOW) begin
				// fill to capacity, push past it, then read it back
				send_command(KIND_CLEAR, $urandom);
				repeat (CAPACITY + 4) begin
					k = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
					send_command(k, push_value());
				end
				send_command(KIND_DUMP_ALL, $urandom);
				send_command(KIND_REMOVE, remove_value());
				send_command(KIND_DUMP_LAST, dump_count());
			end else begin
				repeat (30) begin
					k = choose_kind(seg);
					send_command(k, operand_for(k));
				end
			end
		end
		calm = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d deque commands (%0d directed), checked %0d dump words.",
			commands_sent, directed_cmds, words_checked);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
